// ----- design/pte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_pkg: shared types and constants for the transition enable table
// Command and result transaction layouts, table sizes and mode codes.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int PORTS       = 8;
    localparam int PORT_BITS   = 3;
    localparam int SOURCE_BITS = 8;
    localparam int TOKEN_BITS  = 16;
    localparam int COUNT_BITS  = 4;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    typedef logic [PORTS-1:0][SOURCE_BITS-1:0] source_array_t;
    typedef logic [PORTS-1:0][TOKEN_BITS-1:0]  token_array_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [PORT_BITS-1:0]   port_index;
        logic [SOURCE_BITS-1:0] source_place;
        logic [TOKEN_BITS-1:0]  token_count;
    } cmd_t;

    typedef struct packed {
        logic                   all_filled;
        logic [COUNT_BITS-1:0]  place_count;
        logic                   enabled;
        logic                   place_found;
        logic [SOURCE_BITS-1:0] place_source;
        logic [TOKEN_BITS-1:0]  place_tokens;
        logic [COUNT_BITS-1:0]  place_weight;
    } result_t;

endpackage

// ----- design/petri_transition_enable_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// petri_transition_enable_table: input table of one Petri net transition
// Port entries with source place and tokens; write, token update by source,
// clear and ordered place read-out, with fill and enable status.
// ----------------------------------------------------------------------------
// channel   signals              direction  transfer
// command   start, busy, cmd     in         start && !busy
// result    done, result         out        done, one cycle, no back-pressure
//
// One command transaction per cycle; busy is always low.
// Result path: command register, then table update and place derivation
// into the result register.
// A command in the register sees the table left by the one before it.
// Reset clears valid bits, read pointer and pipeline valids.
// ----------------------------------------------------------------------------
module petri_transition_enable_table (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pte_pkg::cmd_t    cmd,
    output logic             done,
    output pte_pkg::result_t result
);

    pte_pkg::cmd_t                   cmd_reg;
    logic                            cmd_valid_reg;
    logic [pte_pkg::PORTS-1:0]       valid_reg, valid_next;
    pte_pkg::source_array_t          source_reg, source_next;
    pte_pkg::token_array_t           tokens_reg, tokens_next;
    logic [pte_pkg::COUNT_BITS-1:0]  read_ptr_reg, read_ptr_base, read_ptr_next;
    logic                            read_req;
    pte_pkg::result_t                status;
    pte_pkg::result_t                result_reg;
    logic                            done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        source_next   = source_reg;
        tokens_next   = tokens_reg;
        read_ptr_base = read_ptr_reg;
        if (cmd_valid_reg)
        begin
            case (cmd_reg.mode)
                pte_pkg::MODE_WRITE:
                begin
                    valid_next[cmd_reg.port_index]  = 1'b1;
                    source_next[cmd_reg.port_index] = cmd_reg.source_place;
                    tokens_next[cmd_reg.port_index] = cmd_reg.token_count;
                end
                pte_pkg::MODE_UPDATE:
                begin
                    for (int i = 0; i < pte_pkg::PORTS; i++)
                    begin
                        if (valid_reg[i] && (source_reg[i] == cmd_reg.source_place))
                        begin
                            tokens_next[i] = cmd_reg.token_count;
                        end
                    end
                end
                pte_pkg::MODE_CLEAR:
                begin
                    valid_next    = '0;
                    read_ptr_base = '0;
                end
                pte_pkg::MODE_READ:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign read_req = cmd_valid_reg && (cmd_reg.mode == pte_pkg::MODE_READ);

    pte_places u_places (
        .valid        (valid_next),
        .source       (source_next),
        .tokens       (tokens_next),
        .read_pointer (read_ptr_base),
        .read_req     (read_req),
        .status       (status)
    );

    // pointer stays put when reading past the end
    assign read_ptr_next = read_ptr_base
                         + pte_pkg::COUNT_BITS'(status.place_found);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            read_ptr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            read_ptr_reg <= read_ptr_next;
            done_reg     <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        source_reg <= source_next;
        tokens_reg <= tokens_next;
        if (cmd_valid_reg)
        begin
            result_reg <= status;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted command yields its result strobe via the command and result registers
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing after command");

    a_place_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.place_count <= pte_pkg::COUNT_BITS'(pte_pkg::PORTS)))
        else $error("place count exceeds port count");

    // a found place moves the pointer by one in the same update
    a_read_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.place_found) |->
            (read_ptr_reg == ($past(read_ptr_reg) + pte_pkg::COUNT_BITS'(1))))
        else $error("read pointer did not advance on found place");

    a_found_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && (cmd_reg.mode != pte_pkg::MODE_READ)) |=> !result.place_found)
        else $error("place reported outside read command");

endmodule

// ----- design/pte_places.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pte_places: place derivation and status for the transition enable table
// Finds distinct places among valid ports, their weights and order, and
// forms the status and read-out fields of one result.
// ----------------------------------------------------------------------------
module pte_places (
    input  logic [pte_pkg::PORTS-1:0]      valid,
    input  pte_pkg::source_array_t         source,
    input  pte_pkg::token_array_t          tokens,
    input  logic [pte_pkg::COUNT_BITS-1:0] read_pointer,
    input  logic                           read_req,
    output pte_pkg::result_t               status
);

    always_comb
    begin
        logic [pte_pkg::PORTS-1:0]      first;
        logic [pte_pkg::COUNT_BITS-1:0] weight [pte_pkg::PORTS];
        logic [pte_pkg::COUNT_BITS-1:0] rank   [pte_pkg::PORTS];
        logic [pte_pkg::COUNT_BITS-1:0] count;
        logic                           en;

        count = '0;
        for (int i = 0; i < pte_pkg::PORTS; i++)
        begin
            first[i]  = valid[i];
            weight[i] = '0;
            for (int j = 0; j < pte_pkg::PORTS; j++)
            begin
                if (valid[j] && (source[j] == source[i]))
                begin
                    weight[i] = weight[i] + pte_pkg::COUNT_BITS'(1);
                    if (j < i)
                    begin
                        first[i] = 1'b0;
                    end
                end
            end
        end

        // rank = position of the place in first-appearance order
        for (int i = 0; i < pte_pkg::PORTS; i++)
        begin
            rank[i] = count;
            if (first[i])
            begin
                count = count + pte_pkg::COUNT_BITS'(1);
            end
        end

        en = &valid;
        for (int i = 0; i < pte_pkg::PORTS; i++)
        begin
            if (first[i] && (tokens[i] < pte_pkg::TOKEN_BITS'(weight[i])))
            begin
                en = 1'b0;
            end
        end

        status              = '0;
        status.all_filled   = &valid;
        status.place_count  = count;
        status.enabled      = en;
        for (int i = 0; i < pte_pkg::PORTS; i++)
        begin
            if (read_req && first[i] && (rank[i] == read_pointer))
            begin
                status.place_found  = 1'b1;
                status.place_source = source[i];
                status.place_tokens = tokens[i];
                status.place_weight = weight[i];
            end
        end
    end

endmodule
